/* rtl/core/eqzq_pkg.sv */
`timescale 1ns / 1ps

package eqzq_pkg;

  localparam int ANG_W      = 17;
  localparam int CORD_W     = 34;
  localparam int CS_W       = 18;
  localparam int PAIR_W     = 36;
  localparam int TRI_W      = 54;
  localparam int QC_W       = 34;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 32;
  localparam int CS_SHIFT   = 15;
  localparam int OUT_W      = 16;

  localparam logic signed [17:0] FOLD_LIM      = 18'sd23040;
  localparam logic signed [17:0] HALF_TURN     = 18'sd46080;
  localparam logic signed [17:0] DEG8_TO_RAD30 = 18'sd73204;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cordic_lane_t;

  // lane 0 yaw, lane 1 pitch, lane 2 roll
  typedef struct packed {
    cordic_lane_t [2:0] lane;
    logic [2:0]         flip;
  } cordic_word_t;

  typedef struct packed {
    logic [SQ_W-1:0]            rem;
    logic [SQ_W-1:0]            root;
    logic [3:0][QC_W-1:0]       quat;
  } sqrt_word_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [CORD_W-1:0] atan_q30(input int unsigned i);
    logic [CORD_W-1:0] a;
    case (i)
      0:  a = 34'h03243F6A8;
      1:  a = 34'h01DAC6705;
      2:  a = 34'h00FADBAFC;
      3:  a = 34'h007F56EA6;
      4:  a = 34'h003FEAB76;
      5:  a = 34'h001FFD55B;
      6:  a = 34'h000FFFAAA;
      7:  a = 34'h0007FFF55;
      8:  a = 34'h0003FFFEA;
      9:  a = 34'h0001FFFFD;
      10: a = 34'h0000FFFFF;
      11: a = 34'h00007FFFF;
      12: a = 34'h00003FFFF;
      13: a = 34'h00001FFFF;
      14: a = 34'h00000FFFF;
      15: a = 34'h000007FFF;
      16: a = 34'h000003FFF;
      17: a = 34'h000001FFF;
      18: a = 34'h000000FFF;
      19: a = 34'h0000007FF;
      20: a = 34'h0000003FF;
      21: a = 34'h0000001FF;
      22: a = 34'h0000000FF;
      23: a = 34'h00000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/euler_zyx_to_unit_quaternion_unit.sv */
`timescale 1ns / 1ps
// ZYX Euler angles to unit quaternion.
// Input channel: in_valid / in_stall with yaw, pitch and roll in degrees,
// signed, 7 fraction bits. Result channel: out_valid / out_stall with w, x,
// y, z as signed values with OUT_FRAC_BITS fraction bits, saturated to +-1.
// One result per transaction, in order.
// The datapath from acceptance to out_valid is a chain of registered
// cells: one per CORDIC iteration, one per square-root result bit and one
// per quotient bit, plus fold, pair product, triple product, square, sum,
// numerator and output registers. One transaction is taken per cycle
// while out_stall is low.
// Every stage moves on when the stage after it is empty or moving, so a
// stalled receiver holds only the output register and bubbles upstream
// still close up; in_stall rises only once every stage holds a transaction.
// Synchronous reset empties all stages; nothing else needs clearing.
// A zero norm gives the identity quaternion.

module euler_zyx_to_unit_quaternion_unit import eqzq_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ANG_W-1:0] in_yaw_deg,
  input  logic signed [ANG_W-1:0] in_pitch_deg,
  input  logic signed [ANG_W-1:0] in_roll_deg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_quat_w,
  output logic signed [OUT_W-1:0] out_quat_x,
  output logic signed [OUT_W-1:0] out_quat_y,
  output logic signed [OUT_W-1:0] out_quat_z
);

  localparam int QB = OUT_FRAC_BITS + 2;
  localparam int DW = QC_W + 1 + OUT_FRAC_BITS;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << OUT_FRAC_BITS;
  localparam logic [SQ_W-1:0] ONE_64 = SQ_W'(1) << OUT_FRAC_BITS;

  // ---------------- fold and degrees to radians
  logic                    fr_vld_r;
  logic                    fr_rdy;
  cordic_word_t            fr_dat_r;
  cordic_word_t            fr_dat_nxt;
  logic [2:0][ANG_W-1:0]   ang;
  logic signed [17:0]      h;
  logic signed [35:0]      zr;

  assign ang[0] = in_yaw_deg;
  assign ang[1] = in_pitch_deg;
  assign ang[2] = in_roll_deg;

  always_comb begin
    fr_dat_nxt = '0;
    h  = '0;
    zr = '0;
    for (int a = 0; a < 3; a++) begin
      h = $signed({ang[a][ANG_W-1], ang[a]});
      fr_dat_nxt.flip[a] = 1'b0;
      if (h > FOLD_LIM) begin
        h = h - HALF_TURN;
        fr_dat_nxt.flip[a] = 1'b1;
      end else if (h < -FOLD_LIM) begin
        h = h + HALF_TURN;
        fr_dat_nxt.flip[a] = 1'b1;
      end
      zr = h * DEG8_TO_RAD30;
      fr_dat_nxt.lane[a].x = CORDIC_X0;
      fr_dat_nxt.lane[a].y = '0;
      fr_dat_nxt.lane[a].z = zr[CORD_W-1:0];
    end
  end

  // ---------------- CORDIC chain
  logic         cor_vld [CORDIC_STAGES+1];
  logic         cor_rdy [CORDIC_STAGES+1];
  cordic_word_t cor_dat [CORDIC_STAGES+1];

  assign fr_rdy     = !fr_vld_r || cor_rdy[0];
  assign in_stall   = !fr_rdy;
  assign cor_vld[0] = fr_vld_r;
  assign cor_dat[0] = fr_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (fr_rdy) begin
      fr_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_rdy && in_valid) begin
      fr_dat_r <= fr_dat_nxt;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    eqzq_cordic_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .i_vld (cor_vld[g]),
      .i_rdy (cor_rdy[g]),
      .i_dat (cor_dat[g]),
      .o_vld (cor_vld[g+1]),
      .o_rdy (cor_rdy[g+1]),
      .o_dat (cor_dat[g+1])
    );
  end

  // ---------------- cos/sin and pair products
  logic                     pp_vld_r;
  logic                     pp_rdy;
  logic signed [CS_W-1:0]   cs_c [3];
  logic signed [CS_W-1:0]   cs_s [3];
  logic signed [CORD_W-1:0] xf;
  logic signed [CORD_W-1:0] yf;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [PAIR_W-1:0] pcc_r, pss_r, pcs_r, psc_r;
  logic signed [CS_W-1:0]   cy_r, sy_r;

  always_comb begin
    xf = '0;
    yf = '0;
    xs = '0;
    ys = '0;
    for (int a = 0; a < 3; a++) begin
      xf = cor_dat[CORDIC_STAGES].flip[a] ? -cor_dat[CORDIC_STAGES].lane[a].x
                                          : cor_dat[CORDIC_STAGES].lane[a].x;
      yf = cor_dat[CORDIC_STAGES].flip[a] ? -cor_dat[CORDIC_STAGES].lane[a].y
                                          : cor_dat[CORDIC_STAGES].lane[a].y;
      xs = xf >>> CS_SHIFT;
      ys = yf >>> CS_SHIFT;
      cs_c[a] = xs[CS_W-1:0];
      cs_s[a] = ys[CS_W-1:0];
    end
  end

  logic qc_rdy;
  assign pp_rdy                 = !pp_vld_r || qc_rdy;
  assign cor_rdy[CORDIC_STAGES] = pp_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else if (pp_rdy) begin
      pp_vld_r <= cor_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pp_rdy && cor_vld[CORDIC_STAGES]) begin
      pcc_r <= cs_c[2] * cs_c[1];
      pss_r <= cs_s[2] * cs_s[1];
      pcs_r <= cs_c[2] * cs_s[1];
      psc_r <= cs_s[2] * cs_c[1];
      cy_r  <= cs_c[0];
      sy_r  <= cs_s[0];
    end
  end

  // ---------------- triple products to Q30 components
  logic                       qc_vld_r;
  logic [3:0][QC_W-1:0]       qc_r;
  logic [3:0][QC_W-1:0]       qc_nxt;
  logic signed [TRI_W-1:0]    t_ccy, t_ssy, t_scy, t_csy, t_csc, t_scs, t_ccs, t_ssc;
  logic signed [TRI_W:0]      sum_w, sum_x, sum_y, sum_z;
  logic signed [TRI_W:0]      sh_w, sh_x, sh_y, sh_z;

  always_comb begin
    t_ccy = pcc_r * cy_r;
    t_ssy = pss_r * sy_r;
    t_scy = psc_r * cy_r;
    t_csy = pcs_r * sy_r;
    t_csc = pcs_r * cy_r;
    t_scs = psc_r * sy_r;
    t_ccs = pcc_r * sy_r;
    t_ssc = pss_r * cy_r;
    sum_w = t_ccy + t_ssy;
    sum_x = t_scy - t_csy;
    sum_y = t_csc + t_scs;
    sum_z = t_ccs - t_ssc;
    sh_w  = sum_w >>> CS_SHIFT;
    sh_x  = sum_x >>> CS_SHIFT;
    sh_y  = sum_y >>> CS_SHIFT;
    sh_z  = sum_z >>> CS_SHIFT;
    qc_nxt[0] = sh_w[QC_W-1:0];
    qc_nxt[1] = sh_x[QC_W-1:0];
    qc_nxt[2] = sh_y[QC_W-1:0];
    qc_nxt[3] = sh_z[QC_W-1:0];
  end

  logic sq_rdy;
  assign qc_rdy = !qc_vld_r || sq_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qc_vld_r <= 1'b0;
    end else if (qc_rdy) begin
      qc_vld_r <= pp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (qc_rdy && pp_vld_r) begin
      qc_r <= qc_nxt;
    end
  end

  // ---------------- squares
  logic                    sq_vld_r;
  logic [3:0][SQ_W-1:0]    sq_r;
  logic [3:0][SQ_W-1:0]    sq_nxt;
  logic [3:0][QC_W-1:0]    sq_quat_r;
  logic signed [2*QC_W-1:0] sqp;

  always_comb begin
    sqp = '0;
    for (int k = 0; k < 4; k++) begin
      sqp       = $signed(qc_r[k]) * $signed(qc_r[k]);
      sq_nxt[k] = sqp[SQ_W-1:0];
    end
  end

  logic sm_rdy;
  assign sq_rdy = !sq_vld_r || sm_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (sq_rdy) begin
      sq_vld_r <= qc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy && qc_vld_r) begin
      sq_r      <= sq_nxt;
      sq_quat_r <= qc_r;
    end
  end

  // ---------------- sum of squares, then square root chain
  logic       sm_vld_r;
  sqrt_word_t sm_dat_r;
  sqrt_word_t sm_dat_nxt;

  always_comb begin
    sm_dat_nxt.rem  = sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
    sm_dat_nxt.root = '0;
    sm_dat_nxt.quat = sq_quat_r;
  end

  logic       sqr_vld [SQRT_STEPS+1];
  logic       sqr_rdy [SQRT_STEPS+1];
  sqrt_word_t sqr_dat [SQRT_STEPS+1];

  assign sm_rdy     = !sm_vld_r || sqr_rdy[0];
  assign sqr_vld[0] = sm_vld_r;
  assign sqr_dat[0] = sm_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_vld_r <= 1'b0;
    end else if (sm_rdy) begin
      sm_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_rdy && sq_vld_r) begin
      sm_dat_r <= sm_dat_nxt;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    eqzq_sqrt_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .i_vld (sqr_vld[g]),
      .i_rdy (sqr_rdy[g]),
      .i_dat (sqr_dat[g]),
      .o_vld (sqr_vld[g+1]),
      .o_rdy (sqr_rdy[g+1]),
      .o_dat (sqr_dat[g+1])
    );
  end

  // ---------------- numerators: |c| scaled plus half the norm
  logic                   nm_vld_r;
  logic                   nm_rdy;
  logic [3:0][DW-1:0]     nm_rem_r;
  logic [3:0][DW-1:0]     nm_rem_nxt;
  logic [ROOT_W-1:0]      nm_div_r;
  logic [3:0]             nm_neg_r;
  logic [3:0]             nm_neg_nxt;
  logic                   nm_zero_r;
  logic [ROOT_W-1:0]      root_m;
  logic [QC_W-1:0]        mag;

  assign root_m = sqr_dat[SQRT_STEPS].root[ROOT_W-1:0];

  always_comb begin
    mag = '0;
    for (int k = 0; k < 4; k++) begin
      nm_neg_nxt[k] = sqr_dat[SQRT_STEPS].quat[k][QC_W-1];
      mag = nm_neg_nxt[k] ? (~sqr_dat[SQRT_STEPS].quat[k] + QC_W'(1))
                          : sqr_dat[SQRT_STEPS].quat[k];
      nm_rem_nxt[k] = (DW'(mag) << OUT_FRAC_BITS) + DW'(root_m >> 1);
    end
  end

  logic div_vld [QB+1];
  logic div_rdy [QB+1];
  logic [3:0][DW-1:0] div_rem  [QB+1];
  logic [3:0][QB-1:0] div_quo  [QB+1];
  logic [ROOT_W-1:0]  div_div  [QB+1];
  logic [3:0]         div_neg  [QB+1];
  logic               div_zero [QB+1];

  assign nm_rdy              = !nm_vld_r || div_rdy[0];
  assign sqr_rdy[SQRT_STEPS] = nm_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else if (nm_rdy) begin
      nm_vld_r <= sqr_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (nm_rdy && sqr_vld[SQRT_STEPS]) begin
      nm_rem_r  <= nm_rem_nxt;
      nm_div_r  <= root_m;
      nm_neg_r  <= nm_neg_nxt;
      nm_zero_r <= (root_m == '0);
    end
  end

  assign div_vld[0]  = nm_vld_r;
  assign div_rem[0]  = nm_rem_r;
  assign div_quo[0]  = '0;
  assign div_div[0]  = nm_div_r;
  assign div_neg[0]  = nm_neg_r;
  assign div_zero[0] = nm_zero_r;

  // ---------------- quotient chain, most significant bit first
  for (genvar g = 0; g < QB; g++) begin : g_div
    eqzq_div_cell #(.DW(DW), .QB(QB), .BIT(QB - 1 - g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .i_vld  (div_vld[g]),
      .i_rdy  (div_rdy[g]),
      .i_rem  (div_rem[g]),
      .i_quo  (div_quo[g]),
      .i_div  (div_div[g]),
      .i_neg  (div_neg[g]),
      .i_zero (div_zero[g]),
      .o_vld  (div_vld[g+1]),
      .o_rdy  (div_rdy[g+1]),
      .o_rem  (div_rem[g+1]),
      .o_quo  (div_quo[g+1]),
      .o_div  (div_div[g+1]),
      .o_neg  (div_neg[g+1]),
      .o_zero (div_zero[g+1])
    );
  end

  // ---------------- saturate, sign and output register
  logic                    out_vld_r;
  logic                    out_rdy;
  logic [3:0][OUT_W-1:0]   out_r;
  logic [3:0][OUT_W-1:0]   out_nxt;
  logic [QB-1:0]           qsat;
  logic [SQ_W-1:0]         qext;
  logic [SQ_W-1:0]         qsgn;

  always_comb begin
    qsat = '0;
    qext = '0;
    qsgn = '0;
    for (int k = 0; k < 4; k++) begin
      qsat = (div_quo[QB][k] > ONE_Q) ? ONE_Q : div_quo[QB][k];
      qext = SQ_W'(qsat);
      qsgn = div_neg[QB][k] ? (~qext + SQ_W'(1)) : qext;
      out_nxt[k] = qsgn[OUT_W-1:0];
    end
    if (div_zero[QB]) begin
      out_nxt[0] = ONE_64[OUT_W-1:0];
      out_nxt[1] = '0;
      out_nxt[2] = '0;
      out_nxt[3] = '0;
    end
  end

  assign out_rdy     = !out_vld_r || !out_stall;
  assign div_rdy[QB] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= div_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div_vld[QB]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_quat_w = out_r[0];
  assign out_quat_x = out_r[1];
  assign out_quat_y = out_r[2];
  assign out_quat_z = out_r[3];

endmodule

/* rtl/core/eqzq_cordic_cell.sv */
`timescale 1ns / 1ps

module eqzq_cordic_cell import eqzq_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         i_vld,
  output logic         i_rdy,
  input  cordic_word_t i_dat,
  output logic         o_vld,
  input  logic         o_rdy,
  output cordic_word_t o_dat
);

  localparam logic [CORD_W-1:0] ANGLE = atan_q30(STAGE);

  logic         vld_r;
  cordic_word_t dat_r;
  cordic_word_t dat_nxt;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;

  assign i_rdy = !vld_r || o_rdy;
  assign o_vld = vld_r;
  assign o_dat = dat_r;

  always_comb begin
    dat_nxt = i_dat;
    dx = '0;
    dy = '0;
    for (int l = 0; l < 3; l++) begin
      dx = $signed(i_dat.lane[l].y) >>> STAGE;
      dy = $signed(i_dat.lane[l].x) >>> STAGE;
      if (!i_dat.lane[l].z[CORD_W-1]) begin
        dat_nxt.lane[l].x = i_dat.lane[l].x - dx;
        dat_nxt.lane[l].y = i_dat.lane[l].y + dy;
        dat_nxt.lane[l].z = i_dat.lane[l].z - $signed(ANGLE);
      end else begin
        dat_nxt.lane[l].x = i_dat.lane[l].x + dx;
        dat_nxt.lane[l].y = i_dat.lane[l].y - dy;
        dat_nxt.lane[l].z = i_dat.lane[l].z + $signed(ANGLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

/* rtl/core/eqzq_sqrt_cell.sv */
`timescale 1ns / 1ps

module eqzq_sqrt_cell import eqzq_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       i_vld,
  output logic       i_rdy,
  input  sqrt_word_t i_dat,
  output logic       o_vld,
  input  logic       o_rdy,
  output sqrt_word_t o_dat
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

  logic       vld_r;
  sqrt_word_t dat_r;
  sqrt_word_t dat_nxt;
  logic [SQ_W-1:0] trial;

  assign i_rdy = !vld_r || o_rdy;
  assign o_vld = vld_r;
  assign o_dat = dat_r;

  // one result bit per cell
  always_comb begin
    dat_nxt = i_dat;
    trial   = i_dat.root + BIT;
    if (i_dat.rem >= trial) begin
      dat_nxt.rem  = i_dat.rem - trial;
      dat_nxt.root = (i_dat.root >> 1) + BIT;
    end else begin
      dat_nxt.root = i_dat.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

/* rtl/core/eqzq_div_cell.sv */
`timescale 1ns / 1ps

module eqzq_div_cell import eqzq_pkg::*; #(
  parameter int DW  = 49,
  parameter int QB  = 16,
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  i_vld,
  output logic                  i_rdy,
  input  logic [3:0][DW-1:0]    i_rem,
  input  logic [3:0][QB-1:0]    i_quo,
  input  logic [ROOT_W-1:0]     i_div,
  input  logic [3:0]            i_neg,
  input  logic                  i_zero,
  output logic                  o_vld,
  input  logic                  o_rdy,
  output logic [3:0][DW-1:0]    o_rem,
  output logic [3:0][QB-1:0]    o_quo,
  output logic [ROOT_W-1:0]     o_div,
  output logic [3:0]            o_neg,
  output logic                  o_zero
);

  logic                  vld_r;
  logic [3:0][DW-1:0]    rem_r;
  logic [3:0][DW-1:0]    rem_nxt;
  logic [3:0][QB-1:0]    quo_r;
  logic [3:0][QB-1:0]    quo_nxt;
  logic [ROOT_W-1:0]     div_r;
  logic [3:0]            neg_r;
  logic                  zero_r;
  logic [DW-1:0]         dsh;

  assign i_rdy  = !vld_r || o_rdy;
  assign o_vld  = vld_r;
  assign o_rem  = rem_r;
  assign o_quo  = quo_r;
  assign o_div  = div_r;
  assign o_neg  = neg_r;
  assign o_zero = zero_r;

  // restoring step on all four components against the shared divisor
  always_comb begin
    dsh     = DW'(i_div) << BIT;
    rem_nxt = i_rem;
    quo_nxt = i_quo;
    for (int k = 0; k < 4; k++) begin
      if (i_rem[k] >= dsh) begin
        rem_nxt[k]      = i_rem[k] - dsh;
        quo_nxt[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && i_vld) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      div_r  <= i_div;
      neg_r  <= i_neg;
      zero_r <= i_zero;
    end
  end

endmodule

/* rtl/core/eqzq_checker.sv */
`timescale 1ns / 1ps

module eqzq_checker #(
  parameter int OUT_FRAC_BITS = 14
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_quat_w,
  input logic signed [15:0] out_quat_x,
  input logic signed [15:0] out_quat_y,
  input logic signed [15:0] out_quat_z
);

  localparam int LIM = (OUT_FRAC_BITS < 15) ? (1 << OUT_FRAC_BITS) : 32768;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output register empty every stage can move, so input is taken
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // a unit quaternion component never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_quat_w) <= LIM && $signed(out_quat_w) >= -LIM &&
                   $signed(out_quat_x) <= LIM && $signed(out_quat_x) >= -LIM &&
                   $signed(out_quat_y) <= LIM && $signed(out_quat_y) >= -LIM &&
                   $signed(out_quat_z) <= LIM && $signed(out_quat_z) >= -LIM))
    else $error("quaternion component out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quat_w) &&
    $stable(out_quat_x) && $stable(out_quat_y) && $stable(out_quat_z))
    else $error("stalled result changed");

endmodule

bind euler_zyx_to_unit_quaternion_unit eqzq_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_eqzq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_quat_w (out_quat_w),
  .out_quat_x (out_quat_x),
  .out_quat_y (out_quat_y),
  .out_quat_z (out_quat_z)
);
